### src/cbaa_pkg.sv
// Shared types, constants and the control-store program of the chunked bump arena allocator.
`timescale 1ns / 1ps

package cbaa_pkg;

  // Field widths on the ports.
  localparam int REQ_SIZE_W     = 17;
  localparam int CHUNK_BYTES_W  = 17;
  localparam int STATUS_W       = 2;
  localparam int CHUNK_INDEX_W  = 4;
  localparam int OFFSET_W       = 16;

  // A rounded size can carry one bit past the request width.
  localparam int SIZE_W         = REQ_SIZE_W + 1;

  localparam logic [CHUNK_BYTES_W-1:0] CHUNK_BYTES_RST = CHUNK_BYTES_W'(4096);

  // Default pool depth, handed to the top level as its parameter default.
  localparam int MAX_CHUNKS_DEF = 16;

  // Alignment of every allocation. It must be a power of two, so that
  // rounding up is an add and a mask.
  localparam int ALIGN_BYTES = 8;
  localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN_BYTES - 1);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GRANT    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Steps of the control program, in the order of the control store.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_TEST,
    S_GROW,
    S_SH_RD,
    S_SH_WR,
    S_FILL,
    S_OUT
  } step_t;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    OP_INIT,
    OP_IDLE,
    OP_CHECK,
    OP_FETCH,
    OP_TEST,
    OP_GROW,
    OP_SH_RD,
    OP_SH_WR,
    OP_FILL,
    OP_OUT
  } op_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_OVERSIZE,
    C_FIT,
    C_MORE,
    C_FULL,
    C_K_ZERO,
    C_K_ONE,
    C_FILL_MORE,
    C_OUT_BUSY
  } cond_t;

  // One control word: an operation and two prioritized conditional jumps.
  // When neither jump is taken, the step counter advances by one.
  typedef struct packed {
    op_t   op;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      S_INIT:  w = '{OP_INIT,  C_NEVER,     S_INIT,  C_NEVER,  S_INIT};
      S_IDLE:  w = '{OP_IDLE,  C_NO_ACCEPT, S_IDLE,  C_NEVER,  S_INIT};
      S_CHECK: w = '{OP_CHECK, C_OVERSIZE,  S_OUT,   C_NEVER,  S_INIT};
      S_FETCH: w = '{OP_FETCH, C_NEVER,     S_INIT,  C_NEVER,  S_INIT};
      S_TEST:  w = '{OP_TEST,  C_FIT,       S_SH_RD, C_MORE,   S_TEST};
      S_GROW:  w = '{OP_GROW,  C_FULL,      S_OUT,   C_NEVER,  S_INIT};
      S_SH_RD: w = '{OP_SH_RD, C_K_ZERO,    S_FILL,  C_NEVER,  S_INIT};
      S_SH_WR: w = '{OP_SH_WR, C_K_ONE,     S_FILL,  C_ALWAYS, S_SH_WR};
      S_FILL:  w = '{OP_FILL,  C_FILL_MORE, S_FILL,  C_NEVER,  S_INIT};
      S_OUT:   w = '{OP_OUT,   C_OUT_BUSY,  S_OUT,   C_ALWAYS, S_IDLE};
      default: w = '{OP_INIT,  C_ALWAYS,    S_INIT,  C_NEVER,  S_INIT};
    endcase
    return w;
  endfunction

endpackage

### src/cbaa_if.sv
// Request and response channel interfaces of the chunked bump arena allocator.
`timescale 1ns / 1ps

interface cbaa_req_if;
  logic                             valid;
  logic                             ready;
  logic [cbaa_pkg::REQ_SIZE_W-1:0]  req_size;

  modport source (output valid, output req_size, input ready);
  modport sink   (input valid, input req_size, output ready);
endinterface

interface cbaa_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [cbaa_pkg::STATUS_W-1:0]      status;
  logic [cbaa_pkg::CHUNK_INDEX_W-1:0] chunk_index;
  logic [cbaa_pkg::OFFSET_W-1:0]      offset;

  modport source (output valid, output status, output chunk_index, output offset,
                  input ready);
  modport sink   (input valid, input status, input chunk_index, input offset,
                  output ready);
endinterface

### src/chunked_bump_arena_allocator.sv
// Top level of the chunked bump arena allocator: control sequencer, datapath and chunk tables.
`timescale 1ns / 1ps

// Each request word carries a byte size; the block rounds it up to the
// alignment and answers with one response word holding a status, the chunk
// that serves the allocation and the byte offset inside that chunk. Chunks
// are searched in most-recently-used order and the first one with room wins
// and moves to the front. When none has room the pool grows to the next
// power of two of live chunks (capped at MAX_CHUNKS) and the newest chunk
// serves the request at offset zero; a full pool answers "no chunk can be
// added", and a size larger than a chunk answers "too large". Both tables
// (bytes used per chunk and the recency order) live in single-write,
// single-read memories, and a small control program steps the datapath
// through them. A refused oversize request skips the search; otherwise the
// search examines the chunks one after another in recency order, and each
// entry that moves in the recency order is read and rewritten through the
// recency memory in turn. The next request is taken while a response still
// waits on the output. After reset the block seeds the front of both tables
// before it accepts its first request. chunk_bytes may only be written while
// no request is in flight.
module chunked_bump_arena_allocator #(
  parameter int MAX_CHUNKS = cbaa_pkg::MAX_CHUNKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cbaa_pkg::CHUNK_BYTES_W-1:0]  cfg_wdata,
  cbaa_req_if.sink                            in_req,
  cbaa_rsp_if.source                          out_rsp
);

  // Index width for chunk ids and memory addresses, and count width that can
  // also hold MAX_CHUNKS itself.
  localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CW = $clog2(MAX_CHUNKS + 1);

  localparam int SW  = cbaa_pkg::SIZE_W;
  localparam int BW  = cbaa_pkg::CHUNK_BYTES_W;
  localparam int XW  = cbaa_pkg::CHUNK_INDEX_W;
  localparam int OW  = cbaa_pkg::OFFSET_W;
  localparam int STW = cbaa_pkg::STATUS_W;

  // Sequencer state.
  cbaa_pkg::step_t  step_r, step_nxt;
  cbaa_pkg::ucode_t cw;
  logic             hit_a, hit_b;

  // Configuration and pool bookkeeping.
  logic [BW-1:0]  cb_r, cb_nxt;
  logic [CW-1:0]  live_r, live_nxt;

  // Per-request working registers.
  logic [SW-1:0]  size_r, size_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [IW-1:0]  id_r, id_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [CW-1:0]  dist_r, dist_nxt;
  logic [IW-1:0]  base_r, base_nxt;
  logic [CW-1:0]  fcnt_r, fcnt_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  logic           grow_r, grow_nxt;

  // Pending result and output register.
  logic [STW-1:0] res_st_r, res_st_nxt;
  logic [XW-1:0]  res_idx_r, res_idx_nxt;
  logic [OW-1:0]  res_off_r, res_off_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [STW-1:0] out_st_r, out_st_nxt;
  logic [XW-1:0]  out_idx_r, out_idx_nxt;
  logic [OW-1:0]  out_off_r, out_off_nxt;

  // Chunk tables.
  logic [BW-1:0]  used_mem [MAX_CHUNKS];
  logic [IW-1:0]  mru_mem  [MAX_CHUNKS];
  logic           used_we, used_re, mru_we, mru_re;
  logic [IW-1:0]  used_waddr, used_raddr, mru_waddr, mru_raddr;
  logic [BW-1:0]  used_wdata;
  logic [IW-1:0]  mru_wdata;
  logic [BW-1:0]  used_rdata_r;
  logic [IW-1:0]  mru_rdata_r;

  // Datapath arithmetic.
  logic [SW-1:0]    size_rnd;
  logic             oversize;
  logic             over_used;
  logic [BW-1:0]    room;
  logic             fit;
  logic [SW-1:0]    used_plus;
  logic [CW:0]      pos_p1, pos_p2, live_x;
  logic             more;
  logic [CW:0]      tgt_raw;
  logic [CW-1:0]    tgt;
  logic [IW-1:0]    tgt_m1;
  logic             full;
  logic [CW-1:0]    k_m1, k_m2, sh_waddr;
  logic [IW-1:0]    fill_id;
  logic [CW-1:0]    j_p1;
  logic [IW-1:0]    grant_id;
  logic [IW+XW-1:0] grant_ext;
  logic [XW-1:0]    grant_idx;
  logic             out_busy;

  assign cw = cbaa_pkg::ucode_rom(step_r);

  // Size rounding, fit test and pool-growth target.
  always_comb begin
    size_rnd  = (SW'(in_req.req_size) + cbaa_pkg::ALIGN_MASK) & ~cbaa_pkg::ALIGN_MASK;
    oversize  = size_r > SW'(cb_r);
    // A chunk already past the chunk size has no room, yet a zero size still fits.
    over_used = used_rdata_r > cb_r;
    room      = cb_r - used_rdata_r;
    fit       = over_used ? (size_r == '0) : (SW'(room) >= size_r);
    used_plus = SW'(used_rdata_r) + size_r;

    pos_p1 = (CW+1)'(pos_r) + (CW+1)'(1);
    pos_p2 = (CW+1)'(pos_r) + (CW+1)'(2);
    live_x = (CW+1)'(live_r);
    more   = pos_p1 < live_x;

    // Smallest power of two above the live count, then capped at the pool size.
    tgt_raw = '0;
    for (int b = CW; b >= 0; b--) begin
      if (((CW+1)'(1) << b) > live_x) begin
        tgt_raw = (CW+1)'(1) << b;
      end
    end
    if (tgt_raw > (CW+1)'(MAX_CHUNKS)) begin
      tgt_raw = (CW+1)'(MAX_CHUNKS);
    end
    tgt    = tgt_raw[CW-1:0];
    tgt_m1 = IW'(tgt - CW'(1));
    full   = tgt <= live_r;

    k_m1     = k_r - CW'(1);
    k_m2     = k_r - CW'(2);
    sh_waddr = k_m1 + dist_r;
    fill_id  = base_r - j_r[IW-1:0];
    j_p1     = j_r + CW'(1);

    grant_id  = (cw.op == cbaa_pkg::OP_GROW) ? tgt_m1 : id_r;
    grant_ext = {XW'(0), grant_id};
    grant_idx = grant_ext[XW-1:0];

    out_busy = out_valid_r && !out_rsp.ready;
  end

  // Jump conditions.
  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    case (cw.cond_a)
      cbaa_pkg::C_ALWAYS:    hit_a = 1'b1;
      cbaa_pkg::C_NO_ACCEPT: hit_a = !in_req.valid;
      cbaa_pkg::C_OVERSIZE:  hit_a = oversize;
      cbaa_pkg::C_FIT:       hit_a = fit;
      cbaa_pkg::C_MORE:      hit_a = more;
      cbaa_pkg::C_FULL:      hit_a = full;
      cbaa_pkg::C_K_ZERO:    hit_a = (k_r == '0);
      cbaa_pkg::C_K_ONE:     hit_a = (k_r == CW'(1));
      cbaa_pkg::C_FILL_MORE: hit_a = (j_p1 < fcnt_r);
      cbaa_pkg::C_OUT_BUSY:  hit_a = out_busy;
      default:               hit_a = 1'b0;
    endcase
    case (cw.cond_b)
      cbaa_pkg::C_ALWAYS:    hit_b = 1'b1;
      cbaa_pkg::C_NO_ACCEPT: hit_b = !in_req.valid;
      cbaa_pkg::C_OVERSIZE:  hit_b = oversize;
      cbaa_pkg::C_FIT:       hit_b = fit;
      cbaa_pkg::C_MORE:      hit_b = more;
      cbaa_pkg::C_FULL:      hit_b = full;
      cbaa_pkg::C_K_ZERO:    hit_b = (k_r == '0);
      cbaa_pkg::C_K_ONE:     hit_b = (k_r == CW'(1));
      cbaa_pkg::C_FILL_MORE: hit_b = (j_p1 < fcnt_r);
      cbaa_pkg::C_OUT_BUSY:  hit_b = out_busy;
      default:               hit_b = 1'b0;
    endcase
  end

  // Next step and datapath controls decoded from the control word.
  always_comb begin
    if (hit_a) begin
      step_nxt = cw.tgt_a;
    end else if (hit_b) begin
      step_nxt = cw.tgt_b;
    end else begin
      step_nxt = cbaa_pkg::step_t'(step_r + 4'd1);
    end

    cb_nxt        = cfg_we ? cfg_wdata : cb_r;
    live_nxt      = live_r;
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    id_nxt        = id_r;
    k_nxt         = k_r;
    dist_nxt      = dist_r;
    base_nxt      = base_r;
    fcnt_nxt      = fcnt_r;
    j_nxt         = j_r;
    grow_nxt      = grow_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_st_nxt    = out_st_r;
    out_idx_nxt   = out_idx_r;
    out_off_nxt   = out_off_r;

    in_req.ready = 1'b0;
    used_we      = 1'b0;
    used_re      = 1'b0;
    mru_we       = 1'b0;
    mru_re       = 1'b0;
    used_waddr   = '0;
    used_raddr   = '0;
    used_wdata   = '0;
    mru_waddr    = '0;
    mru_raddr    = '0;
    mru_wdata    = '0;

    unique case (cw.op)
      cbaa_pkg::OP_INIT: begin
        // Seed chunk zero: empty and at the front of the recency order.
        used_we = 1'b1;
        mru_we  = 1'b1;
      end
      cbaa_pkg::OP_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          size_nxt = size_rnd;
        end
      end
      cbaa_pkg::OP_CHECK: begin
        pos_nxt     = '0;
        mru_re      = 1'b1;
        res_st_nxt  = cbaa_pkg::ST_OVERSIZE;
        res_idx_nxt = '0;
        res_off_nxt = '0;
      end
      cbaa_pkg::OP_FETCH: begin
        id_nxt     = mru_rdata_r;
        used_re    = 1'b1;
        used_raddr = mru_rdata_r;
        if (more) begin
          mru_re    = 1'b1;
          mru_raddr = pos_p1[IW-1:0];
        end
      end
      cbaa_pkg::OP_TEST: begin
        if (fit) begin
          used_we     = 1'b1;
          used_waddr  = id_r;
          used_wdata  = used_plus[BW-1:0];
          res_st_nxt  = cbaa_pkg::ST_GRANT;
          res_idx_nxt = grant_idx;
          res_off_nxt = used_rdata_r[OW-1:0];
          k_nxt       = pos_r;
          dist_nxt    = CW'(1);
          base_nxt    = id_r;
          fcnt_nxt    = CW'(1);
          j_nxt       = '0;
          grow_nxt    = 1'b0;
        end else if (more) begin
          // The id for the next position is already out of the recency memory.
          pos_nxt    = pos_p1[CW-1:0];
          id_nxt     = mru_rdata_r;
          used_re    = 1'b1;
          used_raddr = mru_rdata_r;
          if (pos_p2 < live_x) begin
            mru_re    = 1'b1;
            mru_raddr = pos_p2[IW-1:0];
          end
        end
      end
      cbaa_pkg::OP_GROW: begin
        if (full) begin
          res_st_nxt  = cbaa_pkg::ST_FULL;
          res_idx_nxt = '0;
          res_off_nxt = '0;
        end else begin
          // Old order slides back by the number of new chunks, which then
          // fill the front, newest first.
          k_nxt       = live_r;
          dist_nxt    = tgt - live_r;
          base_nxt    = tgt_m1;
          fcnt_nxt    = tgt - live_r;
          j_nxt       = '0;
          grow_nxt    = 1'b1;
          live_nxt    = tgt;
          res_st_nxt  = cbaa_pkg::ST_GRANT;
          res_idx_nxt = grant_idx;
          res_off_nxt = '0;
        end
      end
      cbaa_pkg::OP_SH_RD: begin
        if (k_r != '0) begin
          mru_re    = 1'b1;
          mru_raddr = k_m1[IW-1:0];
        end
      end
      cbaa_pkg::OP_SH_WR: begin
        mru_we    = 1'b1;
        mru_waddr = sh_waddr[IW-1:0];
        mru_wdata = mru_rdata_r;
        if (k_r > CW'(1)) begin
          mru_re    = 1'b1;
          mru_raddr = k_m2[IW-1:0];
        end
        k_nxt = k_m1;
      end
      cbaa_pkg::OP_FILL: begin
        mru_we    = 1'b1;
        mru_waddr = j_r[IW-1:0];
        mru_wdata = fill_id;
        if (grow_r) begin
          // The newest chunk takes the request; the others start empty.
          used_we    = 1'b1;
          used_waddr = fill_id;
          used_wdata = (j_r == '0) ? size_r[BW-1:0] : '0;
        end
        j_nxt = j_p1;
      end
      cbaa_pkg::OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_idx_nxt   = res_idx_r;
          out_off_nxt   = res_off_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= cbaa_pkg::S_INIT;
      cb_r        <= cbaa_pkg::CHUNK_BYTES_RST;
      live_r      <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cb_r        <= cb_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    size_r    <= size_nxt;
    pos_r     <= pos_nxt;
    id_r      <= id_nxt;
    k_r       <= k_nxt;
    dist_r    <= dist_nxt;
    base_r    <= base_nxt;
    fcnt_r    <= fcnt_nxt;
    j_r       <= j_nxt;
    grow_r    <= grow_nxt;
    res_st_r  <= res_st_nxt;
    res_idx_r <= res_idx_nxt;
    res_off_r <= res_off_nxt;
    out_st_r  <= out_st_nxt;
    out_idx_r <= out_idx_nxt;
    out_off_r <= out_off_nxt;
  end

  // Bytes used per chunk.
  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    if (used_re) begin
      used_rdata_r <= used_mem[used_raddr];
    end
  end

  // Recency order, most recently used first.
  always_ff @(posedge clk) begin
    if (mru_we) begin
      mru_mem[mru_waddr] <= mru_wdata;
    end
    if (mru_re) begin
      mru_rdata_r <= mru_mem[mru_raddr];
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_st_r;
  assign out_rsp.chunk_index = out_idx_r;
  assign out_rsp.offset      = out_off_r;

endmodule

### tb/cbaa_alloc_checker.sv
// Checker for the chunked bump arena allocator: predicts each allocation and compares responses.
`timescale 1ns / 1ps

module cbaa_alloc_checker #(
  parameter int MAX_CHUNKS = cbaa_pkg::MAX_CHUNKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cbaa_pkg::CHUNK_BYTES_W-1:0]  cfg_wdata,
  cbaa_req_if                                 req_mon,
  cbaa_rsp_if                                 rsp_mon,
  output int                                  fail_count,
  output int                                  outstanding
);
  import cbaa_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CHUNK_INDEX_W-1:0] chunk_index;
    logic [OFFSET_W-1:0]      offset;
  } alloc_rsp_t;

  // Shadow of the pool: chunk size, bump pointers, recency order and live count.
  logic [CHUNK_BYTES_W-1:0] chunk_bytes_now;
  logic [SIZE_W-1:0]        bump_ptr [MAX_CHUNKS];
  int unsigned              recency [MAX_CHUNKS];
  int unsigned              live_count;

  alloc_rsp_t grants_due [$];

  function automatic alloc_rsp_t allocate(input logic [REQ_SIZE_W-1:0] req_bytes);
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] room;
    int unsigned       pos;
    int unsigned       id;
    int unsigned       k;
    int unsigned       target;
    alloc_rsp_t        r;
    r.status      = ST_GRANT;
    r.chunk_index = '0;
    r.offset      = '0;
    size = (SIZE_W'(req_bytes) + SIZE_W'(ALIGN_BYTES - 1)) & ~SIZE_W'(ALIGN_BYTES - 1);
    if (size > SIZE_W'(chunk_bytes_now)) begin
      r.status = ST_OVERSIZE;
      return r;
    end
    // First fit in most-recently-used order; an overfull chunk has no room.
    for (pos = 0; pos < live_count; pos++) begin
      id = recency[pos];
      room = (bump_ptr[id] > SIZE_W'(chunk_bytes_now)) ? '0
                                                       : SIZE_W'(chunk_bytes_now) - bump_ptr[id];
      if (room >= size) begin
        r.chunk_index = CHUNK_INDEX_W'(id);
        r.offset      = OFFSET_W'(bump_ptr[id]);
        bump_ptr[id]  = bump_ptr[id] + size;
        for (k = pos; k > 0; k--) recency[k] = recency[k-1];
        recency[0] = id;
        return r;
      end
    end
    // Nothing fits: grow to the next power of two, newest chunks to the front.
    target = 1;
    while (target <= live_count) target = target << 1;
    if (target > MAX_CHUNKS) target = MAX_CHUNKS;
    if (target <= live_count) begin
      r.status = ST_FULL;
      return r;
    end
    for (id = live_count; id < target; id++) begin
      bump_ptr[id] = '0;
      for (k = id; k > 0; k--) recency[k] = recency[k-1];
      recency[0] = id;
    end
    live_count           = target;
    bump_ptr[target - 1] = size;
    r.chunk_index        = CHUNK_INDEX_W'(target - 1);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst_n) begin
      chunk_bytes_now = CHUNK_BYTES_RST;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        bump_ptr[i] = '0;
        recency[i]  = i;
      end
      live_count = 1;
      grants_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) chunk_bytes_now = cfg_wdata;
      if (req_mon.valid && req_mon.ready) grants_due.push_back(allocate(req_mon.req_size));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grants_due.size() == 0) begin
          $error("response word with no request waiting");
          fail_count++;
        end else begin
          want = grants_due.pop_front();
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
            fail_count++;
          end
          if (rsp_mon.chunk_index !== want.chunk_index) begin
            $error("chunk_index: expected %0d, got %0d", want.chunk_index, rsp_mon.chunk_index);
            fail_count++;
          end
          if (rsp_mon.offset !== want.offset) begin
            $error("offset: expected %0d, got %0d", want.offset, rsp_mon.offset);
            fail_count++;
          end
        end
      end
    end
    outstanding = grants_due.size();
  end

endmodule

### tb/tb_chunked_bump_arena_allocator.sv
// Testbench top for the chunked bump arena allocator: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_chunked_bump_arena_allocator;
  import cbaa_pkg::*;

  // A quiet stretch longer than this means the block is stuck. The longest
  // legal quiet stretch is the deliberate receiver hold-off below plus one
  // slow search, so the limit leaves a wide margin over both.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  // The last words of the run go through with no idling on either side.
  localparam int CALM_TAIL       = 200;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CHUNK_BYTES_W-1:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int rsp_taken = 0;
  int quiet_cycles = 0;
  int tx_idle_pct = 0;
  bit calm = 1'b0;

  cbaa_req_if alloc_req ();
  cbaa_rsp_if alloc_rsp ();

  chunked_bump_arena_allocator #(.MAX_CHUNKS(MAX_CHUNKS_DEF)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (alloc_req),
    .out_rsp   (alloc_rsp)
  );

  cbaa_alloc_checker #(.MAX_CHUNKS(MAX_CHUNKS_DEF)) alloc_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_mon     (alloc_req),
    .rsp_mon     (alloc_rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // The watchdog counts cycles in which neither channel moves a word, and it
  // also keeps the count of response words that the receiver has taken.
  always @(posedge clk) begin
    if (alloc_rsp.valid && alloc_rsp.ready) rsp_taken <= rsp_taken + 1;
    if (!rst_n || (alloc_req.valid && alloc_req.ready) ||
        (alloc_rsp.valid && alloc_rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** chunked_bump_arena_allocator: FAILED **");
        $finish;
      end
    end
  end

  // Receiver. It stalls in random bursts whose density is drawn anew for each
  // span (some stretches do not stall at all), and once, early in the
  // random part, it refuses responses for a long stretch while the sender
  // keeps offering, so the block backs up and has to drop its input ready.
  initial begin : rsp_drain
    int  gap;
    int  span;
    int  rx_idle_pct;
    bit  held;
    held = 1'b0;
    span = 0;
    rx_idle_pct = 0;
    alloc_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        case ($urandom_range(2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 20;
          default: rx_idle_pct = 50;
        endcase
        span = 100;
      end
      span--;
      if (!held && rsp_taken >= 40) begin
        held = 1'b1;
        alloc_rsp.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (!calm && rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
        gap = $urandom_range(11, 1);
        alloc_rsp.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        alloc_rsp.ready <= 1'b1;
      end
    end
  end

  // Offers one request word, possibly after an idle burst, and returns at the
  // falling edge after the word was taken. It is always entered at a falling
  // edge, so valid gets exactly one assignment per time step.
  task automatic offer_word(input logic [REQ_SIZE_W-1:0] bytes);
    int gap;
    if (!calm && tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(11, 1);
      alloc_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    alloc_req.valid    <= 1'b1;
    alloc_req.req_size <= bytes;
    @(posedge clk);
    while (!alloc_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // The chunk size may only change with the block idle, so the request side
  // goes quiet and every outstanding response is drained first.
  task automatic set_chunk_bytes(input logic [CHUNK_BYTES_W-1:0] bytes);
    alloc_req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= bytes;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random request size for a given chunk size. Most words are small so that
  // the search walks through partly filled chunks; a few are zero, a few sit
  // right at the chunk size, and a few span the whole field to hit oversize.
  function automatic logic [REQ_SIZE_W-1:0] pick_size(input logic [CHUNK_BYTES_W-1:0] cb);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    span = (cb >> 3) > 8 ? (cb >> 3) : 8;
    if (roll < 5) return '0;
    if (roll < 12) return REQ_SIZE_W'($urandom_range(17'h1FFFF));
    if (roll < 16 && cb >= 8) return REQ_SIZE_W'($urandom_range(cb, cb - 7));
    if (roll < 55) return REQ_SIZE_W'($urandom_range(64, 1));
    return REQ_SIZE_W'($urandom_range(span, 1));
  endfunction

  initial begin : stimulus
    logic [REQ_SIZE_W-1:0] opening [$];
    int unsigned           phase_cb [8];
    int                    phase_len [8];
    alloc_req.valid    = 1'b0;
    alloc_req.req_size = '0;

    // Directed opening with 64-byte chunks: a zero size, rounding of a one
    // byte request, growth from one chunk to two, three oversize requests
    // (one byte past a chunk, the field's top bit alone and all ones), a fit
    // in the older chunk, then whole chunks until the pool has grown to four,
    // eight and sixteen and finally reports full.
    opening = '{17'd0, 17'd1, 17'd64, 17'd65, 17'd65536, 17'h1FFFF, 17'd56};
    repeat (15) opening.push_back(17'd64);

    // Random phases. Chunk sizes below what the chunks already hold leave
    // them overfull, and the zero and all-ones sizes cover the register's
    // extremes.
    phase_cb  = '{4096, 100, 16384, 0, 1, 65536, 131071, 512};
    phase_len = '{300, 150, 300, 40, 40, 400, 400, 270};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_chunk_bytes(CHUNK_BYTES_W'(64));
    foreach (opening[i]) offer_word(opening[i]);

    // Shrinking the chunks below their bump pointers: a sized request finds
    // no room in a full pool, while a zero size is still granted by the
    // front chunk at its current pointer.
    set_chunk_bytes(CHUNK_BYTES_W'(8));
    offer_word(17'd8);
    offer_word(17'd0);

    foreach (phase_cb[p]) begin
      set_chunk_bytes(CHUNK_BYTES_W'(phase_cb[p]));
      for (int n = 0; n < phase_len[p]; n++) begin
        if (n % 64 == 0) begin
          case ($urandom_range(2))
            0: tx_idle_pct = 0;
            1: tx_idle_pct = 25;
            default: tx_idle_pct = 50;
          endcase
        end
        if (p == 7 && phase_len[p] - n <= CALM_TAIL) calm = 1'b1;
        offer_word(pick_size(CHUNK_BYTES_W'(phase_cb[p])));
      end
    end
    alloc_req.valid <= 1'b0;

    // Drain; the watchdog bounds this wait.
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("** chunked_bump_arena_allocator: PASSED **");
    end else begin
      $display("** chunked_bump_arena_allocator: FAILED **");
    end
    $finish;
  end

endmodule

### chunked_bump_arena_allocator.f
src/cbaa_pkg.sv
src/cbaa_if.sv
src/chunked_bump_arena_allocator.sv
tb/cbaa_alloc_checker.sv
tb/tb_chunked_bump_arena_allocator.sv
